// ----- rtl/bote_pkg.sv -----
// ----------------------------------------------------------------------------
// bote_pkg: shared types and constants of the box overlap / track error block
// Field widths, derived datapath widths and the transfer structs.
// ----------------------------------------------------------------------------
package bote_pkg;

  // Pixel coordinate and size width
  localparam int COORD_BITS  = 12;

  // Doubled center (2*x + w) and box end (x + w)
  localparam int CTR_BITS    = COORD_BITS + 2;
  localparam int END_BITS    = COORD_BITS + 1;

  // Squared center distance and its square root
  localparam int SQ_BITS     = 2 * CTR_BITS + 1;
  localparam int SQ_SCALE    = 6;  // times 64 gives 1/16 pixel after the root
  localparam int ROOT_BITS   = (SQ_BITS + SQ_SCALE + 1) / 2;
  localparam int RAD_BITS    = 2 * ROOT_BITS;

  // Areas and the score divider
  localparam int AREA_BITS   = 2 * COORD_BITS;
  localparam int DEN_BITS    = AREA_BITS + 1;

  localparam int DIST_BITS   = 18;
  localparam int SCORE_BITS  = 17;

  localparam logic [DIST_BITS-1:0]  DIST_MAX  = {DIST_BITS{1'b1}};
  localparam logic [SCORE_BITS-1:0] SCORE_ONE = SCORE_BITS'(1) << (SCORE_BITS - 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] tracked_x;
    logic [COORD_BITS-1:0] tracked_y;
    logic [COORD_BITS-1:0] tracked_w;
    logic [COORD_BITS-1:0] tracked_h;
    logic [COORD_BITS-1:0] truth_x;
    logic [COORD_BITS-1:0] truth_y;
    logic [COORD_BITS-1:0] truth_w;
    logic [COORD_BITS-1:0] truth_h;
  } bote_in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]  center_distance;
    logic [SCORE_BITS-1:0] overlap_score;
  } bote_out_t;

endpackage

// ----- rtl/bote_isqrt.sv -----
// ----------------------------------------------------------------------------
// bote_isqrt: pipelined integer square root
// One result bit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
module bote_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [bote_pkg::RAD_BITS-1:0] in_rad,
  output logic                          out_valid,
  output logic [bote_pkg::ROOT_BITS-1:0] out_root
);
  import bote_pkg::*;

  localparam int REM_BITS = ROOT_BITS + 1;
  localparam int WRK_BITS = REM_BITS + 2;

  logic                 valid_r  [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_r    [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_r    [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_r   [ROOT_BITS];

  logic                 valid_in [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_in   [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_in   [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_in  [ROOT_BITS];
  logic [WRK_BITS-1:0]  rem_sh   [ROOT_BITS];
  logic [WRK_BITS-1:0]  trial    [ROOT_BITS];
  logic                 ge       [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_nxt  [ROOT_BITS];
  logic [REM_BITS-1:0]  rem_nxt  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_nxt [ROOT_BITS];

  always_comb begin
    for (int k = 0; k < ROOT_BITS; k++) begin
      if (k == 0) begin
        valid_in[k] = in_valid;
        rad_in[k]   = in_rad;
        rem_in[k]   = '0;
        root_in[k]  = '0;
      end else begin
        valid_in[k] = valid_r[k-1];
        rad_in[k]   = rad_r[k-1];
        rem_in[k]   = rem_r[k-1];
        root_in[k]  = root_r[k-1];
      end
      // bring down the next two radicand bits, try (4*root + 1)
      rem_sh[k]   = {rem_in[k], rad_in[k][RAD_BITS-1 -: 2]};
      trial[k]    = {1'b0, root_in[k], 2'b01};
      ge[k]       = (rem_sh[k] >= trial[k]);
      rem_nxt[k]  = ge[k] ? REM_BITS'(rem_sh[k] - trial[k]) : REM_BITS'(rem_sh[k]);
      root_nxt[k] = {root_in[k][ROOT_BITS-2:0], ge[k]};
      rad_nxt[k]  = {rad_in[k][RAD_BITS-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ROOT_BITS; k++) valid_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < ROOT_BITS; k++) valid_r[k] <= valid_in[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_BITS; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_valid = valid_r[ROOT_BITS-1];
  assign out_root  = root_r[ROOT_BITS-1];

endmodule

// ----- rtl/bote_div.sv -----
// ----------------------------------------------------------------------------
// bote_div: pipelined overlap score divider
// Computes floor(ov * 2^SCORE_BITS / den), one quotient bit per stage,
// after one entry register. A zero denominator yields zero.
// ----------------------------------------------------------------------------
module bote_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [bote_pkg::AREA_BITS-1:0]  in_ov,
  input  logic [bote_pkg::DEN_BITS-1:0]   in_den,
  output logic                            out_valid,
  output logic [bote_pkg::SCORE_BITS-1:0] out_quo
);
  import bote_pkg::*;

  localparam int WRK_BITS = DEN_BITS + 1;

  logic                  ent_valid_r;
  logic [DEN_BITS-1:0]   ent_rem_r;
  logic [DEN_BITS-1:0]   ent_den_r;
  logic                  ent_zero_r;

  logic                  valid_r [SCORE_BITS];
  logic [DEN_BITS-1:0]   rem_r   [SCORE_BITS];
  logic [DEN_BITS-1:0]   den_r   [SCORE_BITS];
  logic                  zero_r  [SCORE_BITS];
  logic [SCORE_BITS-1:0] quo_r   [SCORE_BITS];

  logic                  valid_in [SCORE_BITS];
  logic [DEN_BITS-1:0]   rem_in   [SCORE_BITS];
  logic [DEN_BITS-1:0]   den_in   [SCORE_BITS];
  logic                  zero_in  [SCORE_BITS];
  logic [SCORE_BITS-1:0] quo_in   [SCORE_BITS];
  logic [WRK_BITS-1:0]   rem_sh   [SCORE_BITS];
  logic                  ge       [SCORE_BITS];
  logic [DEN_BITS-1:0]   rem_nxt  [SCORE_BITS];
  logic [SCORE_BITS-1:0] quo_nxt  [SCORE_BITS];

  always_comb begin
    for (int k = 0; k < SCORE_BITS; k++) begin
      if (k == 0) begin
        valid_in[k] = ent_valid_r;
        rem_in[k]   = ent_rem_r;
        den_in[k]   = ent_den_r;
        zero_in[k]  = ent_zero_r;
        quo_in[k]   = '0;
      end else begin
        valid_in[k] = valid_r[k-1];
        rem_in[k]   = rem_r[k-1];
        den_in[k]   = den_r[k-1];
        zero_in[k]  = zero_r[k-1];
        quo_in[k]   = quo_r[k-1];
      end
      // partial remainder stays below den, so the shifted value stays below 2*den
      rem_sh[k]  = {rem_in[k], 1'b0};
      ge[k]      = (rem_sh[k] >= {1'b0, den_in[k]});
      rem_nxt[k] = ge[k] ? DEN_BITS'(rem_sh[k] - {1'b0, den_in[k]})
                         : DEN_BITS'(rem_sh[k]);
      quo_nxt[k] = {quo_in[k][SCORE_BITS-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      for (int k = 0; k < SCORE_BITS; k++) valid_r[k] <= 1'b0;
    end else begin
      ent_valid_r <= in_valid;
      for (int k = 0; k < SCORE_BITS; k++) valid_r[k] <= valid_in[k];
    end
  end

  always_ff @(posedge clk) begin
    ent_rem_r  <= DEN_BITS'(in_ov);
    ent_den_r  <= in_den;
    ent_zero_r <= (in_den == '0);
    for (int k = 0; k < SCORE_BITS; k++) begin
      rem_r[k]  <= rem_nxt[k];
      den_r[k]  <= den_in[k];
      zero_r[k] <= zero_in[k];
      quo_r[k]  <= quo_nxt[k];
    end
  end

  assign out_valid = valid_r[SCORE_BITS-1];
  assign out_quo   = zero_r[SCORE_BITS-1] ? '0 : quo_r[SCORE_BITS-1];

endmodule

// ----- rtl/box_overlap_track_error.sv -----
// ----------------------------------------------------------------------------
// box_overlap_track_error: per-frame tracking error of a tracked box
// Center distance (1/16 pixel, floored) and Dice overlap score (Q16).
// ----------------------------------------------------------------------------
// Takes one box pair in every clock cycle while busy is low and gives its
// result in order, as a one-cycle out_valid strobe; the receiver cannot
// stall the block and need not. The result passes four stages of center,
// overlap, product and sum logic, then the 18-stage square root and the
// output register; the score divider (entry register and 17 quotient stages)
// runs beside the square root with the same depth. busy is high only while
// reset is applied and for the cycle after it.
// ----------------------------------------------------------------------------
module box_overlap_track_error (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bote_pkg::bote_in_t   in_item,
  output logic                 out_valid,
  output bote_pkg::bote_out_t  out_result
);
  import bote_pkg::*;

  localparam int LATENCY = 4 + ROOT_BITS + 1;

  logic in_accept;

  // stage 1: doubled centers, box ends and starts
  logic                  s1_valid_r;
  logic [CTR_BITS-1:0]   s1_ctx_r, s1_cgx_r, s1_cty_r, s1_cgy_r;
  logic [END_BITS-1:0]   s1_emin_x_r, s1_emin_y_r;
  logic [COORD_BITS-1:0] s1_smax_x_r, s1_smax_y_r;
  logic [COORD_BITS-1:0] s1_tw_r, s1_th_r, s1_gw_r, s1_gh_r;
  logic [END_BITS-1:0]   s1_etx, s1_egx, s1_ety, s1_egy;

  // stage 2: center offsets and overlap sides
  logic                  s2_valid_r;
  logic [CTR_BITS-1:0]   s2_dx_r, s2_dy_r;
  logic [COORD_BITS-1:0] s2_ow_r, s2_oh_r;
  logic [COORD_BITS-1:0] s2_tw_r, s2_th_r, s2_gw_r, s2_gh_r;

  // stage 3: products
  logic                   s3_valid_r;
  logic [2*CTR_BITS-1:0]  s3_dx2_r, s3_dy2_r;
  logic [AREA_BITS-1:0]   s3_ov_r, s3_at_r, s3_ag_r;

  // stage 4: sums
  logic                   s4_valid_r;
  logic [SQ_BITS-1:0]     s4_sq_r;
  logic [DEN_BITS-1:0]    s4_den_r;
  logic [AREA_BITS-1:0]   s4_ov_r;

  logic [RAD_BITS-1:0]    rad;
  logic                   sq_valid;
  logic [ROOT_BITS-1:0]   sq_root;
  logic                   dv_valid;
  logic [SCORE_BITS-1:0]  dv_quo;

  logic                   out_valid_r;
  bote_out_t              out_result_r;
  bote_out_t              out_result_nxt;
  logic                   busy_r;

  // Hold busy through reset and for the cycle after it; the pipeline never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start && !busy_r;

  // Box ends for the overlap extent.
  always_comb begin
    s1_etx = END_BITS'(in_item.tracked_x) + END_BITS'(in_item.tracked_w);
    s1_egx = END_BITS'(in_item.truth_x) + END_BITS'(in_item.truth_w);
    s1_ety = END_BITS'(in_item.tracked_y) + END_BITS'(in_item.tracked_h);
    s1_egy = END_BITS'(in_item.truth_y) + END_BITS'(in_item.truth_h);
  end

  // Advance the valid bits; payload registers below run free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= sq_valid;
    end
  end

  // Stage 1: twice the center is 2*corner + size, an exact integer.
  always_ff @(posedge clk) begin
    s1_ctx_r    <= {1'b0, in_item.tracked_x, 1'b0} + CTR_BITS'(in_item.tracked_w);
    s1_cgx_r    <= {1'b0, in_item.truth_x, 1'b0}   + CTR_BITS'(in_item.truth_w);
    s1_cty_r    <= {1'b0, in_item.tracked_y, 1'b0} + CTR_BITS'(in_item.tracked_h);
    s1_cgy_r    <= {1'b0, in_item.truth_y, 1'b0}   + CTR_BITS'(in_item.truth_h);
    s1_emin_x_r <= (s1_etx < s1_egx) ? s1_etx : s1_egx;
    s1_emin_y_r <= (s1_ety < s1_egy) ? s1_ety : s1_egy;
    s1_smax_x_r <= (in_item.tracked_x > in_item.truth_x) ? in_item.tracked_x
                                                          : in_item.truth_x;
    s1_smax_y_r <= (in_item.tracked_y > in_item.truth_y) ? in_item.tracked_y
                                                          : in_item.truth_y;
    s1_tw_r     <= in_item.tracked_w;
    s1_th_r     <= in_item.tracked_h;
    s1_gw_r     <= in_item.truth_w;
    s1_gh_r     <= in_item.truth_h;
  end

  // Stage 2: absolute center offsets; overlap side is zero when the boxes
  // are disjoint or only touch along that axis.
  always_ff @(posedge clk) begin
    s2_dx_r <= (s1_ctx_r >= s1_cgx_r) ? (s1_ctx_r - s1_cgx_r) : (s1_cgx_r - s1_ctx_r);
    s2_dy_r <= (s1_cty_r >= s1_cgy_r) ? (s1_cty_r - s1_cgy_r) : (s1_cgy_r - s1_cty_r);
    s2_ow_r <= (s1_emin_x_r > END_BITS'(s1_smax_x_r))
               ? COORD_BITS'(s1_emin_x_r - END_BITS'(s1_smax_x_r)) : '0;
    s2_oh_r <= (s1_emin_y_r > END_BITS'(s1_smax_y_r))
               ? COORD_BITS'(s1_emin_y_r - END_BITS'(s1_smax_y_r)) : '0;
    s2_tw_r <= s1_tw_r;
    s2_th_r <= s1_th_r;
    s2_gw_r <= s1_gw_r;
    s2_gh_r <= s1_gh_r;
  end

  // Stage 3: five independent multipliers.
  always_ff @(posedge clk) begin
    s3_dx2_r <= s2_dx_r * s2_dx_r;
    s3_dy2_r <= s2_dy_r * s2_dy_r;
    s3_ov_r  <= s2_ow_r * s2_oh_r;
    s3_at_r  <= s2_tw_r * s2_th_r;
    s3_ag_r  <= s2_gw_r * s2_gh_r;
  end

  // Stage 4: squared doubled distance and area sum.
  always_ff @(posedge clk) begin
    s4_sq_r  <= SQ_BITS'(s3_dx2_r) + SQ_BITS'(s3_dy2_r);
    s4_den_r <= DEN_BITS'(s3_at_r) + DEN_BITS'(s3_ag_r);
    s4_ov_r  <= s3_ov_r;
  end

  // sqrt(64 * (2*d)^2) = 16*d: scale by 64 ahead of the root.
  assign rad = RAD_BITS'({s4_sq_r, {SQ_SCALE{1'b0}}});

  bote_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_valid_r),
    .in_rad    (rad),
    .out_valid (sq_valid),
    .out_root  (sq_root)
  );

  // 2*ov / den in Q16: dividing ov by den with 17 quotient bits.
  bote_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s4_valid_r),
    .in_ov     (s4_ov_r),
    .in_den    (s4_den_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo)
  );

  // Saturate both results at their full-scale values.
  always_comb begin
    out_result_nxt.center_distance =
      (ROOT_BITS'(sq_root) > ROOT_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(sq_root);
    out_result_nxt.overlap_score   = (dv_quo > SCORE_ONE) ? SCORE_ONE : dv_quo;
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // Both arithmetic pipes must stay in step.
  a_pipes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid == dv_valid)
    else $error("square root and divider pipes out of step");

  // Every result strobe traces back to an earlier accepted transfer.
  a_result_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, LATENCY))
    else $error("result strobe without matching transfer");

  // Identical boxes of nonzero size give a full score and zero distance.
  a_identical_boxes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.tracked_x == in_item.truth_x
               && in_item.tracked_y == in_item.truth_y
               && in_item.tracked_w == in_item.truth_w
               && in_item.tracked_h == in_item.truth_h
               && in_item.truth_w != '0 && in_item.truth_h != '0)
    |-> ##LATENCY (out_valid && out_result.overlap_score == SCORE_ONE
                   && out_result.center_distance == '0))
    else $error("identical boxes did not give a full score");

  // The score never exceeds one.
  a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.overlap_score <= SCORE_ONE)
    else $error("overlap score above one");

endmodule
